### rtl/core/lewf_pkg.sv
// Package: constants, types and helpers for the local energy weighted fusion block.
package lewf_pkg;
  localparam int MAX_IMAGES = 4;
  localparam int MAX_WIDTH = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int MAX_WINDOW = 8;
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int IW = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;
  localparam int AW = IW + YW + XW;
  localparam int DEPTH = MAX_IMAGES * MAX_HEIGHT * MAX_WIDTH;
  localparam int LOAD_SLOTS = (MAX_IMAGES < 4) ? MAX_IMAGES : 4;
  localparam int HW = $clog2(MAX_WINDOW / 2 + 1);
  // total energy: up to 4 * 64 * 2^30
  localparam int EW = 40;
  localparam int NW = EW + 17;
  localparam int QW = 17;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_IMAGE_COUNT = 3'd2,
    REG_WINDOW_SIZE = 3'd3,
    REG_ENERGY_FLOOR = 3'd4
  } reg_index_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_WIN,
    ST_CTR,
    ST_ACC,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [5:0] pos_x;
    logic [5:0] pos_y;
    logic [15:0] sample_0;
    logic [15:0] sample_1;
    logic [15:0] sample_2;
    logic [15:0] sample_3;
    logic operation;
  } in_item_t;

  typedef struct packed {
    logic [5:0] out_x;
    logic [5:0] out_y;
    logic [15:0] fused_value;
    logic low_energy;
  } out_item_t;

  typedef struct packed {
    logic [2:0] index;
    logic [15:0] data;
  } cfg_item_t;
endpackage

### rtl/core/lewf_if.sv
// Interfaces: valid/ready stream and configuration write channel.
interface lewf_in_if import lewf_pkg::*; ();
  logic valid;
  logic ready;
  logic operation;
  logic [5:0] pos_x;
  logic [5:0] pos_y;
  logic signed [15:0] sample_0;
  logic signed [15:0] sample_1;
  logic signed [15:0] sample_2;
  logic signed [15:0] sample_3;
  modport source (output valid, operation, pos_x, pos_y, sample_0, sample_1, sample_2,
                  sample_3, input ready);
  modport sink (input valid, operation, pos_x, pos_y, sample_0, sample_1, sample_2,
                sample_3, output ready);
endinterface

interface lewf_out_if ();
  logic valid;
  logic ready;
  logic [5:0] out_x;
  logic [5:0] out_y;
  logic signed [15:0] fused_value;
  logic low_energy;
  modport source (output valid, out_x, out_y, fused_value, low_energy, input ready);
  modport sink (input valid, out_x, out_y, fused_value, low_energy, output ready);
endinterface

interface lewf_cfg_if ();
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/lewf_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module lewf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/local_energy_weighted_fusion.sv
// Local energy weighted fusion: frame store, window energy sequencer and divider.
// Load transaction: one write per image slot, then back to idle.
// Compute: restoring reduction of the coordinates, then per image a window energy sum, a
// centre read and an accumulate, then a restoring divide of weighted sum by total energy.
// One transaction at a time; the result waits in a register until taken.
// Reset (rst, synchronous) restores register defaults and clears control; the
// sample store is not cleared and is undefined until written.
module local_energy_weighted_fusion import lewf_pkg::*; (
  input  logic clk,
  input  logic rst,
  lewf_in_if.sink   in_ch,
  lewf_out_if.source out_ch,
  lewf_cfg_if.sink  cfg
);
  // configuration registers
  logic [6:0]  frame_width, frame_height;
  logic [2:0]  source_count;
  logic [3:0]  window_size;
  logic [15:0] energy_floor;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 7'd64;
      frame_height <= 7'd64;
      source_count <= 3'd4;
      window_size <= 4'd3;
      energy_floor <= 16'd7;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_FRAME_WIDTH:  frame_width <= cfg.data[6:0];
        REG_FRAME_HEIGHT: frame_height <= cfg.data[6:0];
        REG_IMAGE_COUNT:  source_count <= cfg.data[2:0];
        REG_WINDOW_SIZE:  window_size <= cfg.data[3:0];
        REG_ENERGY_FLOOR: energy_floor <= cfg.data;
        default: ;
      endcase
    end
  end

  // saturated working values
  logic [7:0] w_eff, h_eff;
  logic [2:0] n_img;
  logic [HW-1:0] half;
  always_comb begin
    w_eff = (frame_width == 0) ? 8'd1 :
            ({1'b0, frame_width} > 8'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : {1'b0, frame_width};
    h_eff = (frame_height == 0) ? 8'd1 :
            ({1'b0, frame_height} > 8'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : {1'b0, frame_height};
    n_img = (source_count == 0) ? 3'd1 :
            (source_count > 3'(LOAD_SLOTS)) ? 3'(LOAD_SLOTS) : source_count;
    half = (window_size > 4'(MAX_WINDOW)) ? HW'(MAX_WINDOW / 2) : HW'(window_size >> 1);
  end

  state_t state, state_next;

  // transaction registers
  logic       is_load;
  logic [5:0] px, py;
  logic [5:0] cx, cy;
  logic [2:0] mstep;
  logic signed [15:0] ld [4];
  logic [1:0] img;
  logic signed [4:0] kx, ky;
  logic rd_pend;
  logic [EW-1:0] energy, den;
  logic signed [NW-1:0] num;
  // divider
  logic [4:0] dstep;
  logic [NW-1:0] dnum;
  logic [EW:0] drem;
  logic [QW-1:0] quot;
  logic neg;
  out_item_t res;
  logic res_valid;

  // fold of a coordinate into 0..n-1; c lies within -4..n+2
  function automatic logic [5:0] fold(input logic signed [7:0] c, input logic [7:0] n);
    logic signed [8:0] t;
    t = (c < 0) ? -9'(c) : (9'(c) >= $signed({1'b0, n})) ? 9'(c) - $signed({1'b0, n}) : 9'(c);
    // t is at most 4 here, so the remainder needs only small cases
    if (t >= $signed({1'b0, n})) begin
      if (n == 8'd1) t = '0;
      else if (n == 8'd2) t = {8'b0, t[0]};
      else t = t - $signed({1'b0, n});
    end
    return t[5:0];
  endfunction

  // memory addressing
  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [15:0]    wdata, rdata;
  logic [5:0]     fx, fy;

  lewf_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign fx = fold(8'(signed'({1'b0, cx})) + 8'(kx), w_eff);
  assign fy = fold(8'(signed'({1'b0, cy})) + 8'(ky), h_eff);
  assign we = (state == ST_WIN) && is_load;
  assign waddr = {IW'(img), py, px};
  assign wdata = ld[img];
  always_comb begin
    if (state == ST_CTR) raddr = {IW'(img), cy, cx};
    else raddr = {IW'(img), fy, fx};
  end

  assign in_ch.ready = (state == ST_IDLE);
  assign out_ch.valid = res_valid;
  assign out_ch.out_x = res.out_x;
  assign out_ch.out_y = res.out_y;
  assign out_ch.fused_value = res.fused_value;
  assign out_ch.low_energy = res.low_energy;

  logic win_last;
  assign win_last = (kx == 5'(half) - 5'sd1) && (ky == 5'(half) - 5'sd1);
  logic [EW+1:0] trial;
  assign trial = {drem[EW-1:0], dnum[NW-1]} - {2'b0, den};

  // position modulo frame size: restoring reduction, one shifted divisor per cycle
  logic [12:0] wsh, hsh;
  assign wsh = 13'(w_eff) << mstep;
  assign hsh = 13'(h_eff) << mstep;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_ch.valid) state_next = (in_ch.operation == OP_LOAD) ? ST_WIN : ST_MOD;
      end
      ST_MOD: if (mstep == 3'd0) state_next = ST_WIN;
      ST_WIN: begin
        if (is_load) begin
          if (img == 2'(LOAD_SLOTS - 1)) state_next = ST_IDLE;
        end else if (half == 0 || win_last) state_next = ST_CTR;
      end
      ST_CTR: state_next = ST_ACC;
      ST_ACC: state_next = ({1'b0, img} == n_img - 3'd1) ? ST_DIV : ST_WIN;
      ST_DIV: if (dstep == 5'(QW + 1)) state_next = ST_DONE;
      ST_DONE: if (!res_valid) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_ch.valid && out_ch.ready) res_valid <= 1'b0;
      if (state == ST_DONE && !res_valid) res_valid <= 1'b1;
    end
  end

  // datapath
  logic signed [31:0] sq;
  assign sq = $signed(rdata) * $signed(rdata);
  // image energy times centre sample; the centre read lands in rdata during ST_ACC
  logic signed [NW-1:0] prod;
  assign prod = $signed({1'b0, energy}) * $signed(rdata);
  logic [NW-1:0] num_abs;
  assign num_abs = num[NW-1] ? NW'(-num) : NW'(num);
  logic low;
  assign low = (den == 0) || (den < EW'(energy_floor));

  always_ff @(posedge clk) begin
    rd_pend <= 1'b0;
    if (rd_pend) energy <= energy + EW'(unsigned'(sq));
    case (state)
      ST_IDLE: begin
        is_load <= (in_ch.operation == OP_LOAD);
        px <= in_ch.pos_x;
        py <= in_ch.pos_y;
        cx <= in_ch.pos_x;
        cy <= in_ch.pos_y;
        mstep <= 3'd5;
        ld[0] <= in_ch.sample_0;
        ld[1] <= in_ch.sample_1;
        ld[2] <= in_ch.sample_2;
        ld[3] <= in_ch.sample_3;
        img <= '0;
        kx <= -5'(half);
        ky <= -5'(half);
        energy <= '0;
        den <= '0;
        num <= '0;
      end
      ST_MOD: begin
        if ({7'b0, cx} >= wsh) cx <= cx - wsh[5:0];
        if ({7'b0, cy} >= hsh) cy <= cy - hsh[5:0];
        mstep <= mstep - 3'd1;
      end
      ST_WIN: begin
        if (is_load) img <= img + 2'd1;
        else if (half != 0) begin
          rd_pend <= 1'b1;
          if (kx == 5'(half) - 5'sd1) begin
            kx <= -5'(half);
            ky <= ky + 5'sd1;
          end else kx <= kx + 5'sd1;
        end
      end
      ST_ACC: begin
        num <= num + prod;
        den <= den + energy;
        energy <= '0;
        img <= img + 2'd1;
        kx <= -5'(half);
        ky <= -5'(half);
        dstep <= '0;
        drem <= '0;
        quot <= '0;
      end
      ST_DIV: begin
        if (dstep == 5'd0) begin
          // quotient fits QW bits, so the upper numerator bits start as remainder
          neg <= num[NW-1];
          drem <= {1'b0, num_abs[NW-1:QW]};
          dnum <= {num_abs[QW-1:0], {(NW-QW){1'b0}}};
          dstep <= 5'd1;
        end else if (dstep != 5'(QW + 1)) begin
          if (!trial[EW+1]) begin
            drem <= trial[EW:0];
            quot <= {quot[QW-2:0], 1'b1};
          end else begin
            drem <= {drem[EW-1:0], dnum[NW-1]};
            quot <= {quot[QW-2:0], 1'b0};
          end
          dnum <= dnum << 1;
          dstep <= dstep + 5'd1;
        end
      end
      ST_DONE: begin
        if (!res_valid) begin
          res.out_x <= px;
          res.out_y <= py;
          res.low_energy <= low;
          res.fused_value <= low ? 16'd0 : (neg ? 16'(-quot) : quot[15:0]);
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ch.ready) else $error("accepted while busy");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !out_ch.ready) |=> res_valid) else $error("result dropped");
  a_no_write_compute: assert property (@(posedge clk) disable iff (rst)
    we |-> is_load) else $error("store write on compute");
`endif
endmodule
